[src/tag_sector_key_derivation_unit_defines.svh]
// Assertion macros shared by the checker.
`ifndef TAG_SECTOR_KEY_DERIVATION_UNIT_DEFINES_SVH
`define TAG_SECTOR_KEY_DERIVATION_UNIT_DEFINES_SVH

// Property holds on every edge outside reset.
`define TSK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent now, consequent in the next cycle.
`define TSK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tsk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsk_pkg;

    localparam int unsigned TSK_KEY_W     = 48;
    localparam int unsigned TSK_ID_W      = 32;
    localparam int unsigned TSK_SEC_W     = 8;
    localparam int unsigned TSK_DATA_W    = TSK_ID_W + TSK_SEC_W;
    localparam int unsigned TSK_NUM_BYTES = TSK_DATA_W / 8;

    typedef logic [TSK_KEY_W-1:0]  tsk_crc_t;
    typedef logic [TSK_DATA_W-1:0] tsk_data_t;

    // 2*2*3*1103*12868356821
    localparam tsk_crc_t TSK_CRC_SEED = 48'd170325570882756;
    // low 48 bits of 0x42F0E1EBA9EA3693
    localparam tsk_crc_t TSK_CRC_POLY = 48'hE1EB_A9EA_3693;
    // 73*2017*560381651
    localparam tsk_crc_t TSK_ZERO_KEY = 48'd82511154674891;

    // one byte through the MSB-first CRC, byte lands on bits 47..40
    function automatic tsk_crc_t tsk_crc_byte(input tsk_crc_t crc, input logic [7:0] data);
        tsk_crc_t r;
        r = crc ^ {data, 40'd0};
        for (int b = 0; b < 8; b++)
        begin
            if (r[TSK_KEY_W-1])
                r = {r[TSK_KEY_W-2:0], 1'b0} ^ TSK_CRC_POLY;
            else
                r = {r[TSK_KEY_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // low byte ends up in bits 47..40
    function automatic tsk_crc_t tsk_reverse6(input tsk_crc_t v);
        tsk_crc_t r;
        for (int i = 0; i < 6; i++)
        begin
            r[TSK_KEY_W-1-8*i -: 8] = v[8*i +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/tsk_crc_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsk_crc_stage #(
    parameter int unsigned STAGE_IDX = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire tsk_pkg::tsk_crc_t  up_crc,
    input  wire tsk_pkg::tsk_data_t up_data,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output tsk_pkg::tsk_crc_t      dn_crc,
    output tsk_pkg::tsk_data_t     dn_data
);
    import tsk_pkg::*;

    // byte 0 of the request sits at the top of the data word
    localparam int unsigned BYTE_LSB = 8 * (TSK_NUM_BYTES - 1 - STAGE_IDX);

    logic      valid_reg;
    tsk_crc_t  crc_reg;
    tsk_crc_t  crc_next;
    tsk_data_t data_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign crc_next = tsk_crc_byte(up_crc, up_data[BYTE_LSB +: 8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            crc_reg  <= crc_next;
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_crc   = crc_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

[src/tag_sector_key_derivation_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel | valid     | stall     | payload
// request | req_valid | req_stall | tag_id[31:0], sector_number[7:0]
// key     | key_valid | key_stall | sector_key[47:0]
//
// Five register stages, one CRC byte each; one request per cycle while req_stall is low.
// Each stage holds its request until the next stage can take it, so bubbles are squeezed out.
// req_stall rises only when all five stages are full and key_stall is high.
// Reset clears the stage valid bits only.

module tag_sector_key_derivation_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [31:0] tag_id,
    input  wire logic [7:0]  sector_number,
    output logic             key_valid,
    input  wire logic        key_stall,
    output logic [47:0]      sector_key
);
    import tsk_pkg::*;

    logic      valid_chain [0:TSK_NUM_BYTES];
    logic      ready_chain [0:TSK_NUM_BYTES];
    tsk_crc_t  crc_chain   [0:TSK_NUM_BYTES];
    tsk_data_t data_chain  [0:TSK_NUM_BYTES];

    assign valid_chain[0] = req_valid;
    assign crc_chain[0]   = TSK_CRC_SEED;
    assign data_chain[0]  = {tag_id, sector_number};
    assign req_stall      = !ready_chain[0];

    for (genvar s = 0; s < TSK_NUM_BYTES; s++)
    begin : g_stage
        tsk_crc_stage #(
            .STAGE_IDX (s)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_chain[s]),
            .up_ready (ready_chain[s]),
            .up_crc   (crc_chain[s]),
            .up_data  (data_chain[s]),
            .dn_valid (valid_chain[s+1]),
            .dn_ready (ready_chain[s+1]),
            .dn_crc   (crc_chain[s+1]),
            .dn_data  (data_chain[s+1])
        );
    end

    assign ready_chain[TSK_NUM_BYTES] = !key_stall;
    assign key_valid = valid_chain[TSK_NUM_BYTES];

    // sector zero bypasses the CRC result
    assign sector_key = (data_chain[TSK_NUM_BYTES][TSK_SEC_W-1:0] == '0)
                        ? TSK_ZERO_KEY
                        : tsk_reverse6(crc_chain[TSK_NUM_BYTES]);

endmodule

`default_nettype wire

[src/tsk_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "tag_sector_key_derivation_unit_defines.svh"

module tsk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic [7:0]  sector_number,
    input wire logic        key_valid,
    input wire logic        key_stall,
    input wire logic [47:0] sector_key
);
    import tsk_pkg::*;

    logic key_blocked;
    assign key_blocked = key_valid && key_stall;

    // sector zero comes out with the zero key when nothing holds the output
    property p_zero_latency;
        (req_valid && !req_stall && sector_number == '0)
            ##1 !key_stall ##1 !key_stall ##1 !key_stall ##1 !key_stall
            |=> (key_valid && sector_key == TSK_ZERO_KEY);
    endproperty

    // a stalled key holds
    `TSK_ASSERT_NEXT(a_key_hold, key_blocked, key_valid && $stable(sector_key), "stalled key moved")

    // back-pressure only when the output is blocked
    `TSK_ASSERT(a_stall_full, (req_stall |-> key_blocked), "stall with room left")

    `TSK_ASSERT(a_zero_latency, p_zero_latency, "sector zero key late or wrong")

endmodule

bind tag_sector_key_derivation_unit tsk_checker u_tsk_checker (.*);

`default_nettype wire
